[hdl/lkc_pkg.sv]
// Shared types and constants for the LRU key cache.
package lkc_pkg;

    localparam int KEY_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int SLOT_W    = 2;
    localparam int ENTRIES_D = 4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_GET    = 1'b1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // Lookup record that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] min_stamp;
    } t_sweep;

    // Write-back command broadcast to every cell.
    typedef struct packed {
        logic               en;
        logic               set_key;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

[hdl/lkc_cell.sv]
// One cache entry: holds a key and its timestamp and updates the passing lookup record.
module lkc_cell #(
    parameter int IDX_W    = 2,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkc_pkg::t_sweep   i_sweep,
    input  logic [IDX_W-1:0]  i_hit_idx,
    input  logic [IDX_W-1:0]  i_victim_idx,
    input  lkc_pkg::t_wr      i_wr,
    input  logic [IDX_W-1:0]  i_wr_idx,
    output lkc_pkg::t_sweep   o_sweep,
    output logic [IDX_W-1:0]  o_hit_idx,
    output logic [IDX_W-1:0]  o_victim_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [lkc_pkg::KEY_W-1:0]   r_key;
    logic [lkc_pkg::STAMP_W-1:0] r_stamp;
    lkc_pkg::t_sweep             r_sweep;
    lkc_pkg::t_sweep             n_sweep;
    logic [IDX_W-1:0]            r_hit_idx;
    logic [IDX_W-1:0]            n_hit_idx;
    logic [IDX_W-1:0]            r_victim_idx;
    logic [IDX_W-1:0]            n_victim_idx;

    // Fold this entry into the record: first match wins, strict less-than keeps the lower slot.
    always_comb begin
        n_sweep      = i_sweep;
        n_hit_idx    = i_hit_idx;
        n_victim_idx = i_victim_idx;
        if (!i_sweep.found && (r_key == i_sweep.key)) begin
            n_sweep.found = 1'b1;
            n_hit_idx     = MY_IDX;
        end
        if ((CELL_IDX == 0) || (r_stamp < i_sweep.min_stamp)) begin
            n_sweep.min_stamp = r_stamp;
            n_victim_idx      = MY_IDX;
        end
    end

    // Hand the record to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep.valid <= 1'b0;
        end else begin
            r_sweep.valid <= i_sweep.valid;
        end
        r_sweep.found     <= n_sweep.found;
        r_sweep.key       <= n_sweep.key;
        r_sweep.min_stamp <= n_sweep.min_stamp;
        r_hit_idx         <= n_hit_idx;
        r_victim_idx      <= n_victim_idx;
    end

    // Entry storage with write-back from the controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_stamp <= '0;
        end else if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            r_stamp <= i_wr.stamp;
            if (i_wr.set_key) begin
                r_key <= i_wr.key;
            end
        end
    end

    assign o_sweep      = r_sweep;
    assign o_hit_idx    = r_hit_idx;
    assign o_victim_idx = r_victim_idx;

endmodule

[hdl/lkc_ctrl.sv]
// Request control: time counter, sweep launch, write-back and result strobe.
module lkc_ctrl #(
    parameter int IDX_W = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [lkc_pkg::KEY_W-1:0]   i_key,
    output lkc_pkg::t_sweep             o_head,
    output logic [IDX_W-1:0]            o_head_idx,
    input  lkc_pkg::t_sweep             i_tail,
    input  logic [IDX_W-1:0]            i_tail_hit_idx,
    input  logic [IDX_W-1:0]            i_tail_victim_idx,
    output lkc_pkg::t_wr                o_wr,
    output logic [IDX_W-1:0]            o_wr_idx,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [lkc_pkg::SLOT_W-1:0]  o_slot
);

    lkc_pkg::t_state               r_state;
    lkc_pkg::t_state               n_state;
    logic [lkc_pkg::STAMP_W-1:0]   r_time;
    logic [lkc_pkg::STAMP_W-1:0]   n_time;
    logic                          r_kind;
    logic                          n_kind;
    logic                          r_valid;
    logic                          r_hit;
    logic [lkc_pkg::SLOT_W-1:0]    r_slot;
    logic [lkc_pkg::SLOT_W-1:0]    n_slot;
    logic                          accept;

    assign accept = start && (r_state == lkc_pkg::ST_IDLE);
    assign busy   = (r_state != lkc_pkg::ST_IDLE);

    // Next state, request launch and write-back decision.
    always_comb begin
        n_state = r_state;
        n_time  = r_time;
        n_kind  = r_kind;

        o_head.valid     = accept;
        o_head.found     = 1'b0;
        o_head.key       = i_key;
        o_head.min_stamp = lkc_pkg::STAMP_MAX;
        o_head_idx       = '0;

        o_wr.en      = 1'b0;
        o_wr.set_key = !i_tail.found;
        o_wr.key     = i_tail.key;
        o_wr.stamp   = r_time;
        o_wr_idx     = i_tail.found ? i_tail_hit_idx : i_tail_victim_idx;
        n_slot       = '0;

        case (r_state)
            lkc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkc_pkg::ST_SWEEP;
                    n_kind  = i_kind;
                    if (r_time != lkc_pkg::STAMP_MAX) begin
                        n_time = r_time + 1'b1;
                    end
                end
            end
            lkc_pkg::ST_SWEEP: begin
                if (i_tail.valid) begin
                    n_state = lkc_pkg::ST_IDLE;
                    o_wr.en = i_tail.found || (r_kind == lkc_pkg::KIND_INSERT);
                end
            end
            default: begin
                n_state = lkc_pkg::ST_IDLE;
            end
        endcase

        // A get that misses reports slot zero.
        if (i_tail.found) begin
            n_slot = lkc_pkg::SLOT_W'(i_tail_hit_idx);
        end else if (r_kind == lkc_pkg::KIND_INSERT) begin
            n_slot = lkc_pkg::SLOT_W'(i_tail_victim_idx);
        end
    end

    // State, time counter and request kind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkc_pkg::ST_IDLE;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
        end
        r_kind <= n_kind;
    end

    // Result register, strobed for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == lkc_pkg::ST_SWEEP) && i_tail.valid;
        end
        r_hit  <= i_tail.found;
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_slot  = r_slot;

`ifndef ASSERT_OFF
    // The record leaves the row only while a request is in flight.
    a_tail_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tail.valid |-> (r_state == lkc_pkg::ST_SWEEP))
        else $error("lookup record left the cell row while idle");

    // An accepted request makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    // The end of the sweep produces exactly one result strobe and frees the block.
    a_tail_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tail.valid && (r_state == lkc_pkg::ST_SWEEP)) |=> (o_valid && !busy))
        else $error("sweep end did not produce a result");

    // The time counter never moves backward.
    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("time counter decreased");
`endif

endmodule

[hdl/lru_key_cache.sv]
// A request accepted while idle is carried by the lookup record through the row of entry cells,
// one cell per cycle, and then through the result register to the result strobe.
// No new request is taken until after the write-back at the end of the row; busy stays high until then.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset clears every entry to key 0, stamp 0, and the time counter to 0.
module lru_key_cache #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic signed [31:0]          i_key,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [lkc_pkg::SLOT_W-1:0]  o_slot
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    lkc_pkg::t_sweep     sweep     [ENTRIES+1];
    logic [IDX_W-1:0]    hit_idx   [ENTRIES+1];
    logic [IDX_W-1:0]    vic_idx   [ENTRIES+1];
    lkc_pkg::t_wr        wr;
    logic [IDX_W-1:0]    wr_idx;

    // Controller launches requests into the head of the row and reads the tail.
    lkc_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_key             (i_key),
        .o_head            (sweep[0]),
        .o_head_idx        (hit_idx[0]),
        .i_tail            (sweep[ENTRIES]),
        .i_tail_hit_idx    (hit_idx[ENTRIES]),
        .i_tail_victim_idx (vic_idx[ENTRIES]),
        .o_wr              (wr),
        .o_wr_idx          (wr_idx),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_slot            (o_slot)
    );

    assign vic_idx[0] = hit_idx[0];

    // Row of entry cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_sweep      (sweep[g]),
            .i_hit_idx    (hit_idx[g]),
            .i_victim_idx (vic_idx[g]),
            .i_wr         (wr),
            .i_wr_idx     (wr_idx),
            .o_sweep      (sweep[g+1]),
            .o_hit_idx    (hit_idx[g+1]),
            .o_victim_idx (vic_idx[g+1])
        );
    end

endmodule

[dv/lru_key_cache_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key cache: directed table plus random lookups.
module lru_key_cache_tb;

    localparam int ENTRIES      = lkc_pkg::ENTRIES_D;
    localparam int RANDOM_ITEMS = 1150;
    localparam int KEY_POOL     = 6;

    // Expected response of one lookup request.
    typedef struct packed {
        logic                      hit;
        logic [lkc_pkg::SLOT_W-1:0] slot;
    } t_lookup_result;

    // One row of the directed table; typed rows carry their own answer.
    typedef struct packed {
        logic                      kind;
        logic [lkc_pkg::KEY_W-1:0] key;
        logic                      typed;
        logic                      hit;
        logic [lkc_pkg::SLOT_W-1:0] slot;
    } t_lookup_row;

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start   = 1'b0;
    logic                              busy;
    logic                              i_kind  = lkc_pkg::KIND_INSERT;
    logic signed [lkc_pkg::KEY_W-1:0]  i_key   = '0;
    logic                              o_valid;
    logic                              o_hit;
    logic [lkc_pkg::SLOT_W-1:0]        o_slot;

    // Shadow copy of the cache contents and the running time.
    logic [lkc_pkg::KEY_W-1:0]   cache_keys   [ENTRIES];
    logic [lkc_pkg::STAMP_W-1:0] cache_stamps [ENTRIES];
    logic [lkc_pkg::STAMP_W-1:0] time_now;

    t_lookup_result pending_lookups [$];
    t_lookup_row    directed_rows   [$];
    int             mismatch_count = 0;

    lru_key_cache #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_key   (i_key),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_slot  (o_slot)
    );

    always #5 i_clk = ~i_clk;

    // Advance time, look the key up, and apply the hit refresh or the eviction.
    function automatic t_lookup_result lru_predict(logic kind, logic [lkc_pkg::KEY_W-1:0] key);
        t_lookup_result res;
        int found_at;
        int victim;
        found_at = -1;
        victim   = 0;
        res      = '0;
        if (time_now != lkc_pkg::STAMP_MAX) time_now++;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found_at < 0 && cache_keys[i] == key) found_at = i;
        end
        if (found_at >= 0) begin
            cache_stamps[found_at] = time_now;
            res.hit  = 1'b1;
            res.slot = lkc_pkg::SLOT_W'(found_at);
        end else if (kind == lkc_pkg::KIND_INSERT) begin
            for (int i = 1; i < ENTRIES; i++) begin
                if (cache_stamps[i] < cache_stamps[victim]) victim = i;
            end
            cache_keys[victim]   = key;
            cache_stamps[victim] = time_now;
            res.slot = lkc_pkg::SLOT_W'(victim);
        end
        return res;
    endfunction

    // Append one expected response to the tail of the outstanding list.
    task automatic post_expected(t_lookup_result res);
        pending_lookups = {pending_lookups, res};
    endtask

    task automatic add_row(logic kind, logic [lkc_pkg::KEY_W-1:0] key, logic typed,
                           logic hit, logic [lkc_pkg::SLOT_W-1:0] slot);
        t_lookup_row row;
        row.kind  = kind;
        row.key   = key;
        row.typed = typed;
        row.hit   = hit;
        row.slot  = slot;
        directed_rows = {directed_rows, row};
    endtask

    // Idle for a random number of cycles, then hold the request until it is taken.
    task automatic send_request(logic kind, logic [lkc_pkg::KEY_W-1:0] key, logic typed,
                                t_lookup_result typed_res, int idle_pct);
        t_lookup_result predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = lru_predict(kind, key);
        post_expected(typed ? typed_res : predicted);
    endtask

    // Compare every result strobe with the oldest outstanding request.
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result: hit %0b slot %0d", o_hit, o_slot);
                mismatch_count++;
            end else begin
                exp_res = pending_lookups.pop_front();
                if (o_hit !== exp_res.hit) begin
                    $error("hit mismatch: expected %0b, got %0b", exp_res.hit, o_hit);
                    mismatch_count++;
                end
                if (o_slot !== exp_res.slot) begin
                    $error("slot mismatch: expected %0d, got %0d", exp_res.slot, o_slot);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [lkc_pkg::KEY_W-1:0] key_pool [KEY_POOL];
        logic [lkc_pkg::KEY_W-1:0] key;
        logic                      kind;
        t_lookup_result            typed_res;
        int                        idle_pct;

        for (int i = 0; i < ENTRIES; i++) begin
            cache_keys[i]   = '0;
            cache_stamps[i] = '0;
        end
        time_now = '0;

        // Directed table: the answers follow from the reset contents and the LRU order.
        add_row(lkc_pkg::KIND_GET,    32'h0000_0000, 1'b1, 1'b1, 2'd0); // key zero hits after reset
        add_row(lkc_pkg::KIND_GET,    32'h0000_0005, 1'b1, 1'b0, 2'd0); // get miss changes nothing
        add_row(lkc_pkg::KIND_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 2'd1);
        add_row(lkc_pkg::KIND_INSERT, 32'h8000_0000, 1'b1, 1'b0, 2'd2);
        add_row(lkc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd3);
        add_row(lkc_pkg::KIND_INSERT, 32'h0000_0000, 1'b1, 1'b1, 2'd0); // insert of a present key
        add_row(lkc_pkg::KIND_INSERT, 32'h0000_0001, 1'b1, 1'b0, 2'd1);
        add_row(lkc_pkg::KIND_GET,    32'h7FFF_FFFF, 1'b1, 1'b0, 2'd0); // evicted key now misses
        add_row(lkc_pkg::KIND_GET,    32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3);
        add_row(lkc_pkg::KIND_INSERT, 32'h5555_5555, 1'b1, 1'b0, 2'd2);
        add_row(lkc_pkg::KIND_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_GET,    32'h5555_5555, 1'b1, 1'b1, 2'd2);
        add_row(lkc_pkg::KIND_GET,    32'hAAAA_AAAA, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_INSERT, 32'h8000_0000, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_INSERT, 32'h0000_0001, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_GET,    32'h0000_0001, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_GET,    32'h8000_0000, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_INSERT, 32'h0000_0000, 1'b0, 1'b0, 2'd0);
        add_row(lkc_pkg::KIND_GET,    32'h0000_0000, 1'b0, 1'b0, 2'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            typed_res.hit  = directed_rows[r].hit;
            typed_res.slot = directed_rows[r].slot;
            send_request(directed_rows[r].kind, directed_rows[r].key,
                         directed_rows[r].typed, typed_res, 0);
        end

        // A small key pool keeps hits and evictions frequent; fresh keys add misses.
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        typed_res = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS / 3)           idle_pct = 23;
            else if (n < 2 * RANDOM_ITEMS / 3)  idle_pct = 46;
            else                                idle_pct = 0;
            if ($urandom_range(0, 19) == 0)
                key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
            if ($urandom_range(0, 99) < 75)
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else
                key = $urandom;
            kind = ($urandom_range(0, 99) < 55) ? lkc_pkg::KIND_INSERT : lkc_pkg::KIND_GET;
            send_request(kind, key, 1'b0, typed_res, idle_pct);
        end

        // Drain the outstanding results, then allow for any stray strobe.
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
